// ===== sv/ecal_pkg.sv =====
`timescale 1ns / 1ps

package ecal_pkg;

    // Sequencer phases: four restoring divisions, then the year and month walks.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_WDAY,
        ST_YEAR,
        ST_MONTH
    } t_state;

    // Divisors pre-shifted to the top quotient bit of each division.
    localparam logic [31:0] DAY_DVS_INIT  = 32'd2831155200;  // 86400 << 15
    localparam logic [31:0] HOUR_DVS_INIT = 32'd57600;       // 3600 << 4
    localparam logic [31:0] MIN_DVS_INIT  = 32'd1920;        // 60 << 5
    localparam logic [31:0] WDAY_DVS_INIT = 32'd28672;       // 7 << 12

    // Index of the top quotient bit of each division.
    localparam logic [3:0] DAY_STEPS  = 4'd15;
    localparam logic [3:0] HOUR_STEPS = 4'd4;
    localparam logic [3:0] MIN_STEPS  = 4'd5;
    localparam logic [3:0] WDAY_STEPS = 4'd12;

    // Day 0 of the epoch is a Thursday.
    localparam logic [31:0] WDAY_OFFSET = 32'd4;

    // Year walk starts at 1970, with its residues modulo 100 and 400.
    localparam logic [11:0] FIRST_YEAR     = 12'd1970;
    localparam logic [6:0]  FIRST_YEAR_100 = 7'd70;
    localparam logic [8:0]  FIRST_YEAR_400 = 9'd370;
    localparam logic [6:0]  LAST_MOD_100   = 7'd99;
    localparam logic [8:0]  LAST_MOD_400   = 9'd399;
    localparam logic [11:0] YEAR_CODE_BIAS = 12'd48;

    localparam logic [31:0] DAYS_LEAP_YEAR   = 32'd366;
    localparam logic [31:0] DAYS_COMMON_YEAR = 32'd365;

    // December is the last month; the month walk stops there.
    localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

    // Days in a month, month index 0 for January.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon) inside
                4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
                4'd1: len = leap ? 5'd29 : 5'd28;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== sv/epoch_seconds_to_calendar.sv =====
`timescale 1ns / 1ps

// Converts seconds since 1970-01-01 00:00:00 UTC into a UTC calendar date and time.
// Input: a transaction is taken at a rising edge where start is high and busy is low;
// i_epoch_seconds is sampled at that edge. busy stays high until the result is out.
// Output: o_strobe is high for exactly one cycle with all calendar fields valid in that
// cycle. The receiver cannot stall; the result must be taken when it appears.
// Sequence: every step reuses one 32-bit subtract/compare unit. The day, hour, minute and
// weekday restoring divisions run in that order, then the year walk over Y (0..136) whole
// years since 1970 and the month walk over M (0..11) whole months in the final year; Y
// stops at 136 since the input range ends in February 2106. o_strobe rises when the month
// walk ends; busy falls in the same cycle, and a new start may be accepted while the
// strobe is high. One transaction is in flight at a time.
// Reset: i_rst_n is synchronous and active low; it returns the sequencer to idle and
// clears the strobe. The datapath and result registers are not reset.
module epoch_seconds_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_strobe,
    output logic [4:0]  o_hours,
    output logic [5:0]  o_minutes,
    output logic [5:0]  o_seconds,
    output logic [2:0]  o_weekday,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [7:0]  o_year_code
);
    import ecal_pkg::*;

    t_state      r_state,   n_state;
    logic [31:0] r_rem,     n_rem;
    logic [31:0] r_dvs,     n_dvs;
    logic [3:0]  r_cnt,     n_cnt;
    logic [15:0] r_quo,     n_quo;
    logic [15:0] r_days,    n_days;
    logic [11:0] r_year,    n_year;
    logic [6:0]  r_y100,    n_y100;
    logic [8:0]  r_y400,    n_y400;
    logic [3:0]  r_mon,     n_mon;
    logic [4:0]  r_hours,   n_hours;
    logic [5:0]  r_minutes, n_minutes;
    logic [5:0]  r_seconds, n_seconds;
    logic [2:0]  r_wday,    n_wday;
    logic [3:0]  r_month,   n_month;
    logic [4:0]  r_dom,     n_dom;
    logic [7:0]  r_ycode,   n_ycode;
    logic        r_strobe,  n_strobe;

    logic [31:0] w_operand;
    logic [31:0] w_diff;
    logic        w_ge;
    logic        w_leap;
    logic [15:0] w_quo_next;
    logic [11:0] w_ycode_full;

    // Gregorian leap rule, using running residues of the year.
    assign w_leap = (r_year[1:0] == 2'b00) &&
                    ((r_y100 != 7'd0) || (r_y400 == 9'd0));

    // Operand select for the shared unit.
    always_comb begin
        case (r_state)
            ST_YEAR:  w_operand = w_leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
            ST_MONTH: w_operand = {27'd0, month_len(r_mon, w_leap)};
            default:  w_operand = r_dvs;
        endcase
    end

    ecal_sub_unit u_sub (
        .i_a    (r_rem),
        .i_b    (w_operand),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    assign w_quo_next   = {r_quo[14:0], w_ge};
    assign w_ycode_full = r_year + YEAR_CODE_BIAS;

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state   = r_state;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        n_cnt     = r_cnt;
        n_quo     = r_quo;
        n_days    = r_days;
        n_year    = r_year;
        n_y100    = r_y100;
        n_y400    = r_y400;
        n_mon     = r_mon;
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_wday    = r_wday;
        n_month   = r_month;
        n_dom     = r_dom;
        n_ycode   = r_ycode;
        n_strobe  = 1'b0;

        // Common restoring-division step for the four divide phases.
        if (r_state == ST_DAY || r_state == ST_HOUR ||
            r_state == ST_MIN || r_state == ST_WDAY) begin
            if (w_ge) begin
                n_rem = w_diff;
            end
            n_quo = w_quo_next;
            n_dvs = {1'b0, r_dvs[31:1]};
            n_cnt = r_cnt - 4'd1;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_rem   = i_epoch_seconds;
                    n_dvs   = DAY_DVS_INIT;
                    n_cnt   = DAY_STEPS;
                    n_quo   = 16'd0;
                    n_state = ST_DAY;
                end
            end
            ST_DAY: begin
                if (r_cnt == 4'd0) begin
                    n_days  = w_quo_next;
                    n_dvs   = HOUR_DVS_INIT;
                    n_cnt   = HOUR_STEPS;
                    n_quo   = 16'd0;
                    n_state = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (r_cnt == 4'd0) begin
                    n_hours = w_quo_next[4:0];
                    n_dvs   = MIN_DVS_INIT;
                    n_cnt   = MIN_STEPS;
                    n_quo   = 16'd0;
                    n_state = ST_MIN;
                end
            end
            ST_MIN: begin
                if (r_cnt == 4'd0) begin
                    n_minutes = w_quo_next[5:0];
                    n_seconds = w_ge ? w_diff[5:0] : r_rem[5:0];
                    n_rem     = {16'd0, r_days} + WDAY_OFFSET;
                    n_dvs     = WDAY_DVS_INIT;
                    n_cnt     = WDAY_STEPS;
                    n_quo     = 16'd0;
                    n_state   = ST_WDAY;
                end
            end
            ST_WDAY: begin
                if (r_cnt == 4'd0) begin
                    n_wday  = w_ge ? w_diff[2:0] : r_rem[2:0];
                    n_rem   = {16'd0, r_days};
                    n_year  = FIRST_YEAR;
                    n_y100  = FIRST_YEAR_100;
                    n_y400  = FIRST_YEAR_400;
                    n_state = ST_YEAR;
                end
            end
            ST_YEAR: begin
                // Peel off one whole year per cycle while enough days remain.
                if (w_ge) begin
                    n_rem  = w_diff;
                    n_year = r_year + 12'd1;
                    n_y100 = (r_y100 == LAST_MOD_100) ? 7'd0 : r_y100 + 7'd1;
                    n_y400 = (r_y400 == LAST_MOD_400) ? 9'd0 : r_y400 + 9'd1;
                end else begin
                    n_mon   = 4'd0;
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                // Peel off whole months, never past December.
                if (r_mon < LAST_MONTH_IDX && w_ge) begin
                    n_rem = w_diff;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_month  = r_mon + 4'd1;
                    n_dom    = r_rem[4:0] + 5'd1;
                    n_ycode  = w_ycode_full[7:0];
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_dvs     <= n_dvs;
        r_cnt     <= n_cnt;
        r_quo     <= n_quo;
        r_days    <= n_days;
        r_year    <= n_year;
        r_y100    <= n_y100;
        r_y400    <= n_y400;
        r_mon     <= n_mon;
        r_hours   <= n_hours;
        r_minutes <= n_minutes;
        r_seconds <= n_seconds;
        r_wday    <= n_wday;
        r_month   <= n_month;
        r_dom     <= n_dom;
        r_ycode   <= n_ycode;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_hours        = r_hours;
    assign o_minutes      = r_minutes;
    assign o_seconds      = r_seconds;
    assign o_weekday      = r_wday;
    assign o_month        = r_month;
    assign o_day_of_month = r_dom;
    assign o_year_code    = r_ycode;

`ifndef ASSERT_OFF
    // A result only follows the end of the month walk.
    a_strobe_after_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_state) == ST_MONTH)
        else $error("result strobe without a finished month walk");

    // The block is idle again whenever a result is shown.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy)
        else $error("result strobe while still busy");

    // An accepted transaction starts the day division.
    a_start_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_state == ST_DAY)
        else $error("accepted transaction did not start the day division");

    // The month walk never passes December.
    a_month_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MONTH) |-> r_mon <= LAST_MONTH_IDX)
        else $error("month index out of range");

    // Time-of-day fields of a result are in range.
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_hours <= 5'd23 && r_minutes <= 6'd59 &&
                      r_seconds <= 6'd59 && r_wday <= 3'd6))
        else $error("time-of-day field out of range");
`endif

endmodule

// ===== sv/ecal_sub_unit.sv =====
`timescale 1ns / 1ps

module ecal_sub_unit (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_diff,
    output logic        o_ge
);
    logic [32:0] w_full;

    // One wide subtract; the borrow out doubles as the compare result.
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[31:0];
    assign o_ge   = ~w_full[32];

endmodule
